// File: src/skin_pkg.sv
// Shared types and constants of the skeletal vertex skinning block.
package skin_pkg;

	// Vertex numbers count modulo this limit.
	localparam int VERTEX_COUNT_LIMIT = 65536;
	localparam int VTX_CNT_W = $clog2(VERTEX_COUNT_LIMIT);

	// Queue between the rotation front end and the accumulator back end.
	localparam int MID_DEPTH = 8;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int MID_CNT_W = MID_PTR_W + 1;

	// Result queue at the output of the back end.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;

	// One input transaction: one weight contribution of a vertex.
	typedef struct packed {
		logic signed [15:0] joint_qx;
		logic signed [15:0] joint_qy;
		logic signed [15:0] joint_qz;
		logic signed [15:0] joint_qw;
		logic signed [31:0] joint_px;
		logic signed [31:0] joint_py;
		logic signed [31:0] joint_pz;
		logic signed [31:0] weight_x;
		logic signed [31:0] weight_y;
		logic signed [31:0] weight_z;
		logic        [16:0] weight_bias;
		logic               last_weight;
	} weight_t;

	// One result transaction: a finished skinned vertex.
	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic        [15:0] vertex_index;
	} vertex_t;

	// Rotated and translated position, still to be weighted by the bias.
	typedef struct packed {
		logic signed [38:0] pos_x;
		logic signed [38:0] pos_y;
		logic signed [38:0] pos_z;
		logic        [16:0] bias;
		logic               last;
	} mid_item_t;

endpackage

// File: src/skin_front.sv
// Rotation front end: quaternion rotation of the weight offset plus joint position.
module skin_front import skin_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  weight_t              weight,
	input  logic [MID_CNT_W-1:0] mid_count,
	output logic                 mid_push,
	output mid_item_t            mid_data
);

	localparam int OCC_W = MID_CNT_W + 1;

	logic accept;
	logic [OCC_W-1:0] occupancy;

	logic v_s1, v_s2, v_s3;

	// Stage 1: products q*p, named by quaternion component then offset component.
	logic signed [15:0] qx_s1, qy_s1, qz_s1, qw_s1;
	logic signed [31:0] jx_s1, jy_s1, jz_s1;
	logic        [16:0] bias_s1;
	logic               last_s1;
	logic signed [47:0] a_wx_s1, a_wy_s1, a_wz_s1;
	logic signed [47:0] a_xx_s1, a_xy_s1, a_xz_s1;
	logic signed [47:0] a_yx_s1, a_yy_s1, a_yz_s1;
	logic signed [47:0] a_zx_s1, a_zy_s1, a_zz_s1;

	// Stage 2: rounded intermediate quaternion t = q*(p,0).
	logic signed [15:0] qx_s2, qy_s2, qz_s2, qw_s2;
	logic signed [31:0] jx_s2, jy_s2, jz_s2;
	logic        [16:0] bias_s2;
	logic               last_s2;
	logic signed [35:0] tw_s2, tx_s2, ty_s2, tz_s2;
	logic signed [49:0] sum_w, sum_x, sum_y, sum_z;
	logic signed [49:0] rnd_w, rnd_x, rnd_y, rnd_z;

	// Stage 3: products t*q, named by t component then quaternion component.
	logic signed [31:0] jx_s3, jy_s3, jz_s3;
	logic        [16:0] bias_s3;
	logic               last_s3;
	logic signed [51:0] b_xw_s3, b_wx_s3, b_yz_s3, b_zy_s3;
	logic signed [51:0] b_yw_s3, b_wy_s3, b_zx_s3, b_xz_s3;
	logic signed [51:0] b_zw_s3, b_wz_s3, b_xy_s3, b_yx_s3;
	logic signed [51:0] rsum_x, rsum_y, rsum_z;
	logic signed [37:0] rx, ry, rz;

	// Credit check: every item in flight must find a free queue slot.
	assign occupancy = OCC_W'(mid_count) + OCC_W'(v_s1) + OCC_W'(v_s2) + OCC_W'(v_s3);
	assign full      = occupancy >= OCC_W'(MID_DEPTH);
	assign accept    = push && !full;

	// Valid bits of the rotation pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 2 sums, rounded half up by 14 bits.
	always_comb begin
		sum_w = -50'(a_xx_s1) - 50'(a_yy_s1) - 50'(a_zz_s1);
		sum_x = 50'(a_wx_s1) + 50'(a_yz_s1) - 50'(a_zy_s1);
		sum_y = 50'(a_wy_s1) + 50'(a_zx_s1) - 50'(a_xz_s1);
		sum_z = 50'(a_wz_s1) + 50'(a_xy_s1) - 50'(a_yx_s1);
		rnd_w = sum_w + 50'sd8192;
		rnd_x = sum_x + 50'sd8192;
		rnd_y = sum_y + 50'sd8192;
		rnd_z = sum_z + 50'sd8192;
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		qx_s1   <= weight.joint_qx;
		qy_s1   <= weight.joint_qy;
		qz_s1   <= weight.joint_qz;
		qw_s1   <= weight.joint_qw;
		jx_s1   <= weight.joint_px;
		jy_s1   <= weight.joint_py;
		jz_s1   <= weight.joint_pz;
		bias_s1 <= weight.weight_bias;
		last_s1 <= weight.last_weight;
		a_wx_s1 <= 48'(weight.joint_qw) * 48'(weight.weight_x);
		a_wy_s1 <= 48'(weight.joint_qw) * 48'(weight.weight_y);
		a_wz_s1 <= 48'(weight.joint_qw) * 48'(weight.weight_z);
		a_xx_s1 <= 48'(weight.joint_qx) * 48'(weight.weight_x);
		a_xy_s1 <= 48'(weight.joint_qx) * 48'(weight.weight_y);
		a_xz_s1 <= 48'(weight.joint_qx) * 48'(weight.weight_z);
		a_yx_s1 <= 48'(weight.joint_qy) * 48'(weight.weight_x);
		a_yy_s1 <= 48'(weight.joint_qy) * 48'(weight.weight_y);
		a_yz_s1 <= 48'(weight.joint_qy) * 48'(weight.weight_z);
		a_zx_s1 <= 48'(weight.joint_qz) * 48'(weight.weight_x);
		a_zy_s1 <= 48'(weight.joint_qz) * 48'(weight.weight_y);
		a_zz_s1 <= 48'(weight.joint_qz) * 48'(weight.weight_z);

		qx_s2   <= qx_s1;
		qy_s2   <= qy_s1;
		qz_s2   <= qz_s1;
		qw_s2   <= qw_s1;
		jx_s2   <= jx_s1;
		jy_s2   <= jy_s1;
		jz_s2   <= jz_s1;
		bias_s2 <= bias_s1;
		last_s2 <= last_s1;
		tw_s2   <= rnd_w[49:14];
		tx_s2   <= rnd_x[49:14];
		ty_s2   <= rnd_y[49:14];
		tz_s2   <= rnd_z[49:14];

		jx_s3   <= jx_s2;
		jy_s3   <= jy_s2;
		jz_s3   <= jz_s2;
		bias_s3 <= bias_s2;
		last_s3 <= last_s2;
		b_xw_s3 <= 52'(tx_s2) * 52'(qw_s2);
		b_wx_s3 <= 52'(tw_s2) * 52'(qx_s2);
		b_yz_s3 <= 52'(ty_s2) * 52'(qz_s2);
		b_zy_s3 <= 52'(tz_s2) * 52'(qy_s2);
		b_yw_s3 <= 52'(ty_s2) * 52'(qw_s2);
		b_wy_s3 <= 52'(tw_s2) * 52'(qy_s2);
		b_zx_s3 <= 52'(tz_s2) * 52'(qx_s2);
		b_xz_s3 <= 52'(tx_s2) * 52'(qz_s2);
		b_zw_s3 <= 52'(tz_s2) * 52'(qw_s2);
		b_wz_s3 <= 52'(tw_s2) * 52'(qz_s2);
		b_xy_s3 <= 52'(tx_s2) * 52'(qy_s2);
		b_yx_s3 <= 52'(ty_s2) * 52'(qx_s2);
	end

	// Vector part of t*conj(q), rounded half up by 14 bits, plus the joint position.
	always_comb begin
		rsum_x = b_xw_s3 - b_wx_s3 - b_yz_s3 + b_zy_s3 + 52'sd8192;
		rsum_y = b_yw_s3 - b_wy_s3 - b_zx_s3 + b_xz_s3 + 52'sd8192;
		rsum_z = b_zw_s3 - b_wz_s3 - b_xy_s3 + b_yx_s3 + 52'sd8192;
		rx = rsum_x[51:14];
		ry = rsum_y[51:14];
		rz = rsum_z[51:14];
		mid_data.pos_x = 39'(jx_s3) + 39'(rx);
		mid_data.pos_y = 39'(jy_s3) + 39'(ry);
		mid_data.pos_z = 39'(jz_s3) + 39'(rz);
		mid_data.bias  = bias_s3;
		mid_data.last  = last_s3;
	end

	assign mid_push = v_s3;

endmodule

// File: src/skin_queue.sv
// Short queue that decouples the rotation front end from the accumulator back end.
module skin_queue import skin_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mid_item_t            push_data,
	input  logic                 pop,
	output logic                 empty,
	output mid_item_t            head,
	output logic [MID_CNT_W-1:0] count
);

	mid_item_t            mem [MID_DEPTH];
	logic [MID_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [MID_CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign head  = mem[rd_ptr_q];
	assign count = count_q;

	// Storage; the front end never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + MID_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + MID_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + MID_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - MID_CNT_W'(1);
			end
		end
	end

endmodule

// File: src/skin_back.sv
// Accumulator back end: bias weighting, saturating accumulation and result queue.
module skin_back import skin_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_empty,
	input  mid_item_t mid_head,
	output logic      mid_pop,
	output logic      empty,
	input  logic      pop,
	output vertex_t   vertex
);

	localparam int OCC_W = OUT_CNT_W + 1;

	// Saturate a sum to the 56 bit accumulator range.
	function automatic logic signed [55:0] sat56(input logic signed [56:0] v);
		if (v[56] != v[55]) begin
			return v[56] ? {1'b1, {55{1'b0}}} : {1'b0, {55{1'b1}}};
		end
		return v[55:0];
	endfunction

	// Saturate an accumulator to the Q16.16 output range.
	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		if ((&v[55:31]) || !(|v[55:31])) begin
			return v[31:0];
		end
		return v[55] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
	endfunction

	logic [OCC_W-1:0] occupancy;

	logic               v_s1;
	logic               last_s1;
	logic signed [56:0] px_s1, py_s1, pz_s1;

	logic signed [57:0] rnd_x, rnd_y, rnd_z;
	logic signed [41:0] cx, cy, cz;
	logic signed [55:0] nx, ny, nz;

	logic signed [55:0]   sum_x_q, sum_y_q, sum_z_q;
	logic [VTX_CNT_W-1:0] cnt_q;

	logic               v_s2;
	logic signed [55:0] ex_s2, ey_s2, ez_s2;
	logic        [15:0] idx_s2;

	vertex_t              out_mem [OUT_DEPTH];
	vertex_t              out_data;
	logic [OUT_PTR_W-1:0] out_wr_q, out_rd_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;
	logic                 out_push, out_pop;

	// Take a transaction only if every result in flight has a result slot.
	assign occupancy = OCC_W'(out_cnt_q) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign mid_pop   = !mid_empty && (occupancy < OCC_W'(OUT_DEPTH));

	// Contribution rounded half up by 16 bits, then the saturating add.
	always_comb begin
		rnd_x = 58'(px_s1) + 58'sd32768;
		rnd_y = 58'(py_s1) + 58'sd32768;
		rnd_z = 58'(pz_s1) + 58'sd32768;
		cx = rnd_x[57:16];
		cy = rnd_y[57:16];
		cz = rnd_z[57:16];
		nx = sat56(57'(sum_x_q) + 57'(cx));
		ny = sat56(57'(sum_y_q) + 57'(cy));
		nz = sat56(57'(sum_z_q) + 57'(cz));
	end

	// Bias products and the finished vertex awaiting the result queue.
	always_ff @(posedge clk) begin
		px_s1   <= 57'(mid_head.pos_x) * 57'($signed({1'b0, mid_head.bias}));
		py_s1   <= 57'(mid_head.pos_y) * 57'($signed({1'b0, mid_head.bias}));
		pz_s1   <= 57'(mid_head.pos_z) * 57'($signed({1'b0, mid_head.bias}));
		last_s1 <= mid_head.last;
		if (v_s1 && last_s1) begin
			ex_s2  <= nx;
			ey_s2  <= ny;
			ez_s2  <= nz;
			idx_s2 <= 16'(cnt_q);
		end
	end

	// Accumulators, vertex counter and stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1 && last_s1;
			if (v_s1) begin
				if (last_s1) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					sum_z_q <= '0;
					if (cnt_q == VTX_CNT_W'(VERTEX_COUNT_LIMIT - 1)) begin
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + VTX_CNT_W'(1);
					end
				end else begin
					sum_x_q <= nx;
					sum_y_q <= ny;
					sum_z_q <= nz;
				end
			end
		end
	end

	// Result queue.
	assign out_push = v_s2;
	assign out_pop  = pop && !empty;
	assign empty    = out_cnt_q == '0;
	assign vertex   = out_mem[out_rd_q];

	always_comb begin
		out_data.vertex_x     = sat32(ex_s2);
		out_data.vertex_y     = sat32(ey_s2);
		out_data.vertex_z     = sat32(ez_s2);
		out_data.vertex_index = idx_s2;
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem[out_wr_q] <= out_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) begin
				out_wr_q <= out_wr_q + OUT_PTR_W'(1);
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + OUT_PTR_W'(1);
			end
			if (out_push && !out_pop) begin
				out_cnt_q <= out_cnt_q + OUT_CNT_W'(1);
			end else if (out_pop && !out_push) begin
				out_cnt_q <= out_cnt_q - OUT_CNT_W'(1);
			end
		end
	end

endmodule

// File: src/skeletal_vertex_skinning.sv
// Top level of the skeletal vertex skinning block (linear blend, fixed point).
//
// Input channel: a transaction carries one weight of a vertex (joint quaternion
// Q1.14, joint position and weight offset Q16.16, bias Q1.16, last flag). It is
// taken at a clock edge with push high and full low.
// Result channel: while empty is low the oldest finished vertex is on the
// vertex port; it is taken at a clock edge with pop high. One result is made
// for each input transaction flagged last, none for the others.
// Path of a last weight: three rotation stages, the decoupling queue, bias
// multiply, accumulate. Throughput: up to one weight per clock cycle while full
// is low; the rate is set by the rotation pipeline and the single accumulator,
// each one transaction a cycle.
// When pop stays low the result queue fills, the back end stops draining the
// middle queue, and full rises once the middle queue and the rotation
// pipeline hold as many weights as the queue has slots. Nothing is lost.
// Reset clears the accumulators, the vertex counter and both queues.
module skeletal_vertex_skinning import skin_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  weight_t weight,
	output logic    empty,
	input  logic    pop,
	output vertex_t vertex
);

	logic                 mid_push, mid_pop, mid_empty;
	mid_item_t            mid_data, mid_head;
	logic [MID_CNT_W-1:0] mid_count;

	skin_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.weight    (weight),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_data  (mid_data)
	);

	skin_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mid_push),
		.push_data (mid_data),
		.pop       (mid_pop),
		.empty     (mid_empty),
		.head      (mid_head),
		.count     (mid_count)
	);

	skin_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.vertex    (vertex)
	);

endmodule
